### hw/rtl/checksummed_frame_receiver_macros.svh
// Assertion macros used by the frame receiver RTL.
// Each assertion is sampled on clk's rising edge; CFR_ASSERT is off while rst_n is low.
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFR_ASSERT(lbl, prop, msg)
`define CFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/cfr_pkg.sv
`timescale 1ns / 1ps
package cfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 16;
  localparam int HEAD_DEPTH = 4;
  localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t HDR_BYTE        = 8'hA5;
  localparam byte_t TRL_BYTE        = 8'h5A;
  localparam byte_t ZERO_BYTE       = 8'h00;
  localparam byte_t PAYLOAD_LEN_RST = 8'd4;

  // One decoded frame: two little-endian signed samples.
  typedef struct packed {
    logic signed [CHAN_W-1:0] channel_a;
    logic signed [CHAN_W-1:0] channel_b;
  } cfr_result_t;

endpackage

### hw/rtl/cfr_in_if.sv
`timescale 1ns / 1ps
interface cfr_in_if
  import cfr_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/cfr_out_if.sv
`timescale 1ns / 1ps
interface cfr_out_if
  import cfr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CHAN_W-1:0] channel_a;
  logic signed [CHAN_W-1:0] channel_b;

  modport source (output valid, output channel_a, output channel_b, input ready);
  modport sink   (input valid, input channel_a, input channel_b, output ready);
endinterface

### hw/rtl/cfr_in_stage.sv
`timescale 1ns / 1ps
module cfr_in_stage
  import cfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  cfr_in_if.sink   in_ch,
  input  logic     take_i,
  output logic     vld_o,
  output byte_t    byte_o
);

  logic  vld_r, vld_nxt;
  byte_t byte_r;

  // The register refills in the same cycle that its byte is consumed.
  assign in_ch.ready = !vld_r || take_i;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.ready) begin
      vld_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign vld_o  = vld_r;
  assign byte_o = byte_r;

endmodule

### hw/rtl/cfr_parser.sv
`timescale 1ns / 1ps
`include "checksummed_frame_receiver_macros.svh"
module cfr_parser
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  byte_t       payload_len_i,
  input  logic        step_i,
  input  byte_t       byte_i,
  output logic        emit_o,
  output cfr_result_t res_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CHECK,
    PH_TRAIL
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  cnt_r, cnt_nxt;
  byte_t  sum_r, sum_nxt;
  byte_t  head_r [HEAD_DEPTH];
  logic   head_we;
  logic   emit;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    head_we   = 1'b0;
    emit      = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (byte_i == HDR_BYTE) begin
          cnt_nxt   = ZERO_BYTE;
          sum_nxt   = ZERO_BYTE;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        head_we = (cnt_r < BYTE_W'(HEAD_DEPTH));
        sum_nxt = sum_r + byte_i;
        cnt_nxt = cnt_r + 8'd1;
        // A length of zero wraps the counter and means 256 bytes.
        if (cnt_nxt == payload_len_i) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // The failing byte is dropped, not checked as a new header.
        phase_nxt = (byte_i == sum_r) ? PH_TRAIL : PH_HUNT;
      end
      PH_TRAIL: begin
        emit      = (byte_i == TRL_BYTE);
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= ZERO_BYTE;
      sum_r   <= ZERO_BYTE;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && head_we) begin
      head_r[cnt_r[HEAD_IDX_W-1:0]] <= byte_i;
    end
  end

  assign emit_o          = step_i && emit;
  assign res_o.channel_a = {head_r[1], head_r[0]};
  assign res_o.channel_b = {head_r[3], head_r[2]};

  `CFR_ASSERT(a_emit_in_trail, emit_o |-> (phase_r == PH_TRAIL), "frame emitted outside trailer")
  `CFR_ASSERT(a_hold_no_step, !step_i |=> $stable(phase_r) && $stable(sum_r), "parser moved without a byte")
  `CFR_ASSERT(a_sum_update, step_i && (phase_r == PH_PAYLOAD) |=> sum_r == $past(sum_r + byte_i), "running sum wrong")

endmodule

### hw/rtl/cfr_out_stage.sv
`timescale 1ns / 1ps
module cfr_out_stage
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cfr_out_if.source   out_ch,
  input  logic        ld_i,
  input  cfr_result_t res_i,
  output logic        can_take_o
);

  logic        vld_r, vld_nxt;
  cfr_result_t res_r;

  assign can_take_o = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (can_take_o) begin
      vld_nxt = ld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_i && can_take_o) begin
      res_r <= res_i;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.channel_a = res_r.channel_a;
  assign out_ch.channel_b = res_r.channel_b;

endmodule

### hw/rtl/checksummed_frame_receiver.sv
`timescale 1ns / 1ps
// Path: a frame's result passes the input and result registers before reaching out_ch.
// Throughput: one byte per cycle unless stalled; the input register refills on drain.
// Stalls: a full result register with out_ch.ready low holds the parser and input.
// Reset: rst_n is synchronous, active low; it clears the parser to header hunting,
// empties both registers and sets payload_len to 4. Stored payload bytes are not reset.
module checksummed_frame_receiver
  import cfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  byte_t      cfg_wdata,
  cfr_in_if.sink     in_ch,
  cfr_out_if.source  out_ch
);

  // The payload length register. The user must write it only while no transaction
  // is in flight (not enforced by the block), so the parser may read it directly.
  byte_t       payload_len_r;

  logic        byte_vld;
  byte_t       byte_q;
  logic        can_take;
  logic        step;
  logic        emit;
  cfr_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_len_r <= PAYLOAD_LEN_RST;
    end else if (cfg_we) begin
      payload_len_r <= cfg_wdata;
    end
  end

  // Every received byte lands in the input register first.
  cfr_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .take_i (step),
    .vld_o  (byte_vld),
    .byte_o (byte_q)
  );

  // The parser advances on a byte only when a possible result has room to
  // go, so no frame result can be lost while the consumer stalls.
  assign step = byte_vld && can_take;

  cfr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .payload_len_i (payload_len_r),
    .step_i        (step),
    .byte_i        (byte_q),
    .emit_o        (emit),
    .res_o         (res)
  );

  // The result register lets new bytes flow while the consumer takes the
  // previous result.
  cfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_ch     (out_ch),
    .ld_i       (emit),
    .res_i      (res),
    .can_take_o (can_take)
  );

endmodule

### tb/checksummed_frame_receiver_checker.sv
`timescale 1ns / 1ps
module checksummed_frame_receiver_checker
  import cfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  byte_t     cfg_wdata,
  cfr_in_if         in_mon,
  cfr_out_if        out_mon,
  output int        error_count,
  output int        frames_pending
);

  typedef enum logic [1:0] {
    SEEK_HEADER,
    TAKE_PAYLOAD,
    MATCH_SUM,
    MATCH_TRAILER
  } parse_phase_t;

  parse_phase_t parse_phase;
  byte_t        payload_len;
  byte_t        payload_count;
  byte_t        payload_sum;
  byte_t        first_bytes [HEAD_DEPTH];
  cfr_result_t  decoded_frames [$];

  initial error_count = 0;
  initial frames_pending = 0;

  // Advances the parser by one received byte and queues a decoded frame when a
  // trailer closes a frame whose checksum matched.
  task automatic parse_rx_byte(input byte_t b);
    cfr_result_t frame;
    case (parse_phase)
      SEEK_HEADER: begin
        if (b == HDR_BYTE) begin
          payload_count = ZERO_BYTE;
          payload_sum   = ZERO_BYTE;
          parse_phase   = TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        if (payload_count < HEAD_DEPTH)
          first_bytes[payload_count[HEAD_IDX_W-1:0]] = b;
        payload_sum   = payload_sum + b;
        payload_count = payload_count + 8'd1;
        if (payload_count == payload_len)
          parse_phase = MATCH_SUM;
      end
      MATCH_SUM: begin
        parse_phase = (b == payload_sum) ? MATCH_TRAILER : SEEK_HEADER;
      end
      default: begin
        if (b == TRL_BYTE) begin
          frame.channel_a = {first_bytes[1], first_bytes[0]};
          frame.channel_b = {first_bytes[3], first_bytes[2]};
          decoded_frames.push_back(frame);
        end
        parse_phase = SEEK_HEADER;
      end
    endcase
  endtask

  always @(posedge clk) begin
    cfr_result_t want;
    if (!rst_n) begin
      parse_phase   = SEEK_HEADER;
      payload_len   = PAYLOAD_LEN_RST;
      payload_count = ZERO_BYTE;
      payload_sum   = ZERO_BYTE;
      decoded_frames.delete();
    end else begin
      // A result never stems from a byte taken at the same edge, so results
      // are checked before the byte of this edge is parsed.
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_frames.size() == 0) begin
          $error("unexpected frame result: channel_a %0d, channel_b %0d",
                 out_mon.channel_a, out_mon.channel_b);
          error_count++;
        end else begin
          want = decoded_frames.pop_front();
          if (out_mon.channel_a !== want.channel_a) begin
            $error("channel_a: expected %0d, got %0d", want.channel_a, out_mon.channel_a);
            error_count++;
          end
          if (out_mon.channel_b !== want.channel_b) begin
            $error("channel_b: expected %0d, got %0d", want.channel_b, out_mon.channel_b);
            error_count++;
          end
        end
      end
      if (cfg_we)
        payload_len = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        parse_rx_byte(in_mon.rx_byte);
    end
    frames_pending <= decoded_frames.size();
  end

endmodule

### tb/checksummed_frame_receiver_test.sv
`timescale 1ns / 1ps
module checksummed_frame_receiver_test;
  import cfr_pkg::*;

  // Clock period is 12 ns, so the clock toggles every 6 ns.
  localparam int HALF_PERIOD_NS = 6;
  // Cycles allowed after the last expected result for any byte still inside
  // the block to be parsed; results pass the input and result registers.
  localparam int SETTLE_CYCLES  = 8;
  // Length of the deliberate result-side stall that backs the block up.
  localparam int HOLD_CYCLES    = 400;
  // Frame bytes spread over the phases that use short payloads.
  localparam int RANDOM_BYTES   = 300;
  localparam int SHORT_PHASES   = 10;
  // Hard stop for a hung run, far beyond the slowest legal run.
  localparam int TIMEOUT_NS     = 4_000_000;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TRAILER,
    FRAME_CUT_SHORT,
    LINE_NOISE
  } frame_kind_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  byte_t cfg_wdata;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  int    error_count;
  int    frames_pending;
  // When set, neither side inserts idle cycles.
  bit    steady;
  // Set by the stimulus to ask the result side for one long stall.
  bit    stall_request;
  // Payload length the block is currently programmed with.
  byte_t cur_len;
  // Bytes sent as part of framed traffic, used to size the random phases.
  int    frame_bytes_sent;

  checksummed_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  checksummed_frame_receiver_checker frame_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .error_count    (error_count),
    .frames_pending (frames_pending)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Watchdog: a run that hangs on a lost result or a stuck handshake ends here.
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Result side. Ready is normally low about 30 percent of the time. On
  // request it holds ready low for a long, counted stretch so that the result
  // register fills, the parser stalls and the input side backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // Offers one byte and returns at the edge where the transaction completes.
  // Must be called at a rising edge. Random idle cycles come first, so gaps
  // land at every point of a frame. Valid is left high, so back-to-back bytes
  // never see valid drop and rise in the same time step.
  task automatic send_byte(input byte_t b);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending and waits for every expected result, then lets the block
  // finish parsing any bytes that produce no result. Configuration writes
  // only happen after this.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_payload_len(input byte_t len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_len   = len;
  endtask

  // Sends one frame of the given kind at the current payload length. Payload
  // bytes are random, with the header value mixed in often so that it shows
  // up inside payloads. A programmed length of zero means 256 payload bytes.
  task automatic send_frame(input frame_kind_t kind);
    int    n_payload;
    int    n_send;
    byte_t sum;
    byte_t b;
    n_payload = (cur_len == ZERO_BYTE) ? 256 : int'(cur_len);
    if (kind == LINE_NOISE) begin
      repeat ($urandom_range(4, 1)) send_byte(byte_t'($urandom()));
    end else begin
      n_send = (kind == FRAME_CUT_SHORT) ? $urandom_range(n_payload - 1, 0) : n_payload;
      sum = ZERO_BYTE;
      send_byte(HDR_BYTE);
      for (int i = 0; i < n_send; i++) begin
        b = ($urandom_range(9) == 0) ? HDR_BYTE : byte_t'($urandom());
        sum = sum + b;
        send_byte(b);
      end
      frame_bytes_sent += n_send + 1;
      if (kind != FRAME_CUT_SHORT) begin
        // A corrupted checksum always differs from the true sum.
        if (kind == FRAME_BAD_SUM)
          send_byte(sum ^ byte_t'($urandom_range(255, 1)));
        else
          send_byte(sum);
        if (kind == FRAME_BAD_TRAILER) begin
          b = ($urandom_range(1) == 0) ? HDR_BYTE : byte_t'($urandom());
          if (b == TRL_BYTE)
            b = ZERO_BYTE;
          send_byte(b);
        end else begin
          send_byte(TRL_BYTE);
        end
        frame_bytes_sent += 2;
      end
    end
  endtask

  // Mostly clean frames, the rest broken in the ways a noisy line breaks them.
  function automatic frame_kind_t pick_frame_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)      return FRAME_GOOD;
    else if (r < 78) return FRAME_BAD_SUM;
    else if (r < 86) return FRAME_BAD_TRAILER;
    else if (r < 93) return FRAME_CUT_SHORT;
    else             return LINE_NOISE;
  endfunction

  // Opening sequence at the reset payload length of four:
  // a clean frame carrying the most negative and most positive samples,
  // a frame whose bad checksum byte equals the header value, which must not
  // restart a frame, and a frame whose wrong trailer equals the header value,
  // which must not restart one either.
  byte_t opening_bytes [20] = '{
    HDR_BYTE, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFE, TRL_BYTE,
    HDR_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, HDR_BYTE,
    HDR_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC, HDR_BYTE
  };

  // Payload length per phase. The first phase carries the long result-side
  // stall, the seventh runs with no idle cycles on either side. Lengths below
  // four reuse stored bytes of earlier frames, which the opening sequence has
  // already filled. Zero stands for 256 payload bytes and 250 is the other
  // long extreme; each long length gets a single frame.
  byte_t len_plan [12] = '{
    8'd4, 8'd5, 8'd1, 8'd2, 8'd3, 8'd250, 8'd8, 8'd0, 8'd6, 8'd9, 8'd12, 8'd7
  };

  initial begin
    int    target;
    bit    long_len;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = ZERO_BYTE;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = ZERO_BYTE;
    steady           = 1'b0;
    stall_request    = 1'b0;
    cur_len          = PAYLOAD_LEN_RST;
    frame_bytes_sent = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i])
      send_byte(opening_bytes[i]);

    foreach (len_plan[p]) begin
      // Every phase starts from a quiet block: all results in, nothing left
      // in flight, then the new length is written.
      drain();
      write_payload_len(len_plan[p]);
      long_len = (len_plan[p] == ZERO_BYTE) || (len_plan[p] > 8'd64);
      steady   = (p == 6);
      if (p == 0) begin
        // Back the block up: the result side stalls while clean frames keep
        // coming, so the input side must stall too.
        stall_request = 1'b1;
        repeat (6) send_frame(FRAME_GOOD);
      end
      if (long_len) begin
        send_frame(FRAME_GOOD);
      end else begin
        target = frame_bytes_sent + RANDOM_BYTES / SHORT_PHASES;
        while (frame_bytes_sent < target)
          send_frame(pick_frame_kind());
      end
      steady = 1'b0;
    end

    drain();
    if (error_count == 0 && frames_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
